### rtl/balist_pkg.sv
// Shared types and codes for the bounded array list engine.
// No dependencies; every other file imports this package.
package balist_pkg;

   // Default list depth and the widest position/count the design supports
   localparam int CAPACITY_DEFAULT = 128;
   localparam int CAPACITY_MAX     = 4096;
   localparam int POS_W            = $clog2(CAPACITY_MAX + 1);
   localparam int DATA_W           = 32;
   localparam int GROUP_SIZE       = 16;

   typedef enum logic [3:0] {
      CMD_CLEAR        = 4'd0,
      CMD_PREPEND      = 4'd1,
      CMD_INSERT_AT    = 4'd2,
      CMD_APPEND       = 4'd3,
      CMD_REMOVE_FIRST = 4'd4,
      CMD_REMOVE_AT    = 4'd5,
      CMD_READ_AT      = 4'd6,
      CMD_REPLACE_AT   = 4'd7,
      CMD_SWAP         = 4'd8,
      CMD_READ_HEAD    = 4'd9
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_BADPOS = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_INSERT,
      OP_REMOVE,
      OP_REPLACE,
      OP_SWAP
   } op_type;

   // Broadcast from the sequencer to every cell of the chain
   typedef struct packed {
      logic              commit;
      op_type            op;
      logic [POS_W-1:0]  pos_a;
      logic [POS_W-1:0]  pos_b;
      logic [DATA_W-1:0] wr_value;
      logic [DATA_W-1:0] rd_a;
      logic [DATA_W-1:0] rd_b;
   } cell_ctrl_type;

endpackage

### rtl/balist_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on balist_pkg for widths.
interface balist_req_if import balist_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [3:0]               cmd;
   logic signed [DATA_W-1:0] value;
   logic [7:0]               position;
   logic [6:0]               second_position;

   modport source (output valid, cmd, value, position, second_position, input ready);
   modport sink   (input valid, cmd, value, position, second_position, output ready);
endinterface

interface balist_rsp_if import balist_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               status;
   logic signed [DATA_W-1:0] data;
   logic [7:0]               count;
   logic                     is_empty;

   modport source (output valid, status, data, count, is_empty, input ready);
   modport sink   (input valid, status, data, count, is_empty, output ready);
endinterface

### rtl/balist_cell.sv
// One storage cell of the list chain: holds one element, takes from its
// neighbours on shifts and drives read taps. Depends on balist_pkg.
module balist_cell import balist_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic [DATA_W-1:0] left_value,
   input  logic [DATA_W-1:0] right_value,
   output logic [DATA_W-1:0] value,
   output logic [DATA_W-1:0] tap_a,
   output logic [DATA_W-1:0] tap_b
);

   localparam logic [POS_W-1:0] MY_INDEX = POS_W'(INDEX);

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (MY_INDEX > ctrl.pos_a) value_in = left_value;
            else if (MY_INDEX == ctrl.pos_a) value_in = ctrl.wr_value;
         end
         OP_REMOVE: begin
            if (MY_INDEX >= ctrl.pos_a) value_in = right_value;
         end
         OP_REPLACE: begin
            if (MY_INDEX == ctrl.pos_a) value_in = ctrl.wr_value;
         end
         OP_SWAP: begin
            if (MY_INDEX == ctrl.pos_a) value_in = ctrl.rd_b;
            else if (MY_INDEX == ctrl.pos_b) value_in = ctrl.rd_a;
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) value_ff <= value_in;
   end

   assign value = value_ff;
   assign tap_a = (MY_INDEX == ctrl.pos_a) ? value_ff : '0;
   assign tap_b = (MY_INDEX == ctrl.pos_b) ? value_ff : '0;

endmodule

### rtl/balist_gather.sv
// Two-level registered OR tree that collects the one selected cell tap.
// Depends on balist_pkg.
module balist_gather import balist_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                             clock,
   input  logic [CAPACITY-1:0][DATA_W-1:0]  taps,
   output logic [DATA_W-1:0]                word
);

   localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   logic [NUM_GROUPS-1:0][DATA_W-1:0] group_ff;
   logic [NUM_GROUPS-1:0][DATA_W-1:0] group_in;
   logic [DATA_W-1:0]                 word_ff;
   logic [DATA_W-1:0]                 word_in;

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < CAPACITY) group_in[g] = group_in[g] | taps[g * GROUP_SIZE + k];
         end
      end
   end

   always_comb begin
      word_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) word_in = word_in | group_ff[g];
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
      word_ff  <= word_in;
   end

   assign word = word_ff;

endmodule

### rtl/bounded_array_list_engine_core.sv
// A request accepted in S_IDLE passes S_READ1 and S_READ2 while the two-level
// read tree over the cell chain settles, then S_EXEC commits it, shifting all cells
// in parallel, and registers its response; no new request is taken until then.
// A response waiting on rsp stalls the commit cycle, not the read cycles.
// Reset (synchronous, active high) empties the list and drops any pending
// response; cell contents are left as they are and are never read unwritten.
module bounded_array_list_engine_core import balist_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   balist_req_if.sink     req,
   balist_rsp_if.source   rsp
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ1,
      S_READ2,
      S_EXEC
   } state_type;

   state_type         state_ff;
   logic [CNT_W-1:0]  count_ff;

   // Captured request decision
   op_type            op_ff;
   logic [POS_W-1:0]  pos_a_ff;
   logic [POS_W-1:0]  pos_b_ff;
   logic [DATA_W-1:0] wr_value_ff;
   logic              take_data_ff;
   status_type        status_ff;
   logic [CNT_W-1:0]  count_next_ff;

   // Response registers
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [7:0]        rsp_count_ff;
   logic              rsp_empty_ff;

   // Decode of the incoming request
   op_type            op_in;
   logic [POS_W-1:0]  pos_a_in;
   logic              take_data_in;
   status_type        status_in;
   logic [CNT_W-1:0]  count_in;

   logic [POS_W-1:0]  count_ext;
   logic [POS_W-1:0]  pos_ext;
   logic [POS_W-1:0]  pos2_ext;
   logic [POS_W-1:0]  cnt_next_ext;
   logic              full;
   logic              p1_ok;
   logic              p2_ok;
   logic              out_free;
   logic              commit;

   logic [CAPACITY-1:0][DATA_W-1:0] cell_value;
   logic [CAPACITY-1:0][DATA_W-1:0] taps_a;
   logic [CAPACITY-1:0][DATA_W-1:0] taps_b;
   logic [DATA_W-1:0]               rd_a;
   logic [DATA_W-1:0]               rd_b;
   cell_ctrl_type                   ctrl;

   assign count_ext = POS_W'(count_ff);
   assign pos_ext   = POS_W'(req.position);
   assign pos2_ext  = POS_W'(req.second_position);
   assign full      = count_ext >= CAP_POS;
   assign p1_ok     = pos_ext < count_ext;
   assign p2_ok     = pos2_ext < count_ext;

   // Work out status, cell operation and new count up front; the cells only
   // carry out what is decided here.
   always_comb begin
      op_in        = OP_NONE;
      pos_a_in     = pos_ext;
      take_data_in = 1'b0;
      status_in    = ST_OK;
      count_in     = count_ff;
      case (req.cmd)
         CMD_CLEAR: count_in = '0;
         CMD_PREPEND: begin
            pos_a_in = '0;
            if (full) status_in = ST_FULL;
            else begin
               op_in    = OP_INSERT;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_INSERT_AT: begin
            if (full) status_in = ST_FULL;
            else if (pos_ext > count_ext) status_in = ST_BADPOS;
            else begin
               op_in    = OP_INSERT;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_APPEND: begin
            pos_a_in = count_ext;
            if (full) status_in = ST_FULL;
            else begin
               op_in    = OP_INSERT;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_REMOVE_FIRST: begin
            pos_a_in = '0;
            if (count_ff == '0) status_in = ST_EMPTY;
            else begin
               op_in        = OP_REMOVE;
               take_data_in = 1'b1;
               count_in     = count_ff - 1'b1;
            end
         end
         CMD_REMOVE_AT: begin
            if (!p1_ok) status_in = ST_BADPOS;
            else begin
               op_in        = OP_REMOVE;
               take_data_in = 1'b1;
               count_in     = count_ff - 1'b1;
            end
         end
         CMD_READ_AT: begin
            if (!p1_ok) status_in = ST_BADPOS;
            else take_data_in = 1'b1;
         end
         CMD_REPLACE_AT: begin
            if (!p1_ok) status_in = ST_BADPOS;
            else begin
               op_in        = OP_REPLACE;
               take_data_in = 1'b1;
            end
         end
         CMD_SWAP: begin
            if (!p1_ok || !p2_ok) status_in = ST_BADPOS;
            else op_in = OP_SWAP;
         end
         CMD_READ_HEAD: begin
            pos_a_in = '0;
            if (count_ff == '0) status_in = ST_EMPTY;
            else take_data_in = 1'b1;
         end
         default: op_in = OP_NONE;   // unused codes: change nothing, answer ok
      endcase
   end

   assign req.ready    = (state_ff == S_IDLE);
   assign out_free     = !rsp_valid_ff || rsp.ready;
   assign commit       = (state_ff == S_EXEC) && out_free;
   assign cnt_next_ext = POS_W'(count_next_ff);

   // Sequencer: accept, read through the tree in S_READ1 and S_READ2, then commit
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop a taken response unless a new one replaces it this cycle
         if (rsp_valid_ff && rsp.ready && !commit) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  op_ff         <= op_in;
                  pos_a_ff      <= pos_a_in;
                  pos_b_ff      <= pos2_ext;
                  wr_value_ff   <= req.value;
                  take_data_ff  <= take_data_in;
                  status_ff     <= status_in;
                  count_next_ff <= count_in;
                  state_ff      <= S_READ1;
               end
            end
            S_READ1: state_ff <= S_READ2;
            S_READ2: state_ff <= S_EXEC;
            S_EXEC: begin
               // Hold here while the previous response has not been taken
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_data_ff   <= take_data_ff ? rd_a : '0;
                  rsp_count_ff  <= cnt_next_ext[7:0];
                  rsp_empty_ff  <= (count_next_ff == '0);
                  count_ff      <= count_next_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign ctrl.commit   = commit;
   assign ctrl.op       = op_ff;
   assign ctrl.pos_a    = pos_a_ff;
   assign ctrl.pos_b    = pos_b_ff;
   assign ctrl.wr_value = wr_value_ff;
   assign ctrl.rd_a     = rd_a;
   assign ctrl.rd_b     = rd_b;

   // Chain of cells; each neighbour pair exchanges values for shifts
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_value;
      logic [DATA_W-1:0] right_value;
      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_left
         assign left_value = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_right
         assign right_value = cell_value[i+1];
      end
      balist_cell #(.INDEX(i)) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[i]),
         .tap_a       (taps_a[i]),
         .tap_b       (taps_b[i])
      );
   end

   balist_gather #(.CAPACITY(CAPACITY)) u_gather_a (
      .clock (clock),
      .taps  (taps_a),
      .word  (rd_a)
   );

   balist_gather #(.CAPACITY(CAPACITY)) u_gather_b (
      .clock (clock),
      .taps  (taps_b),
      .word  (rd_b)
   );

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.status   = rsp_status_ff;
   assign rsp.data     = rsp_data_ff;
   assign rsp.count    = rsp_count_ff;
   assign rsp.is_empty = rsp_empty_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_exec_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && rsp_valid_ff && !rsp.ready) |=> state_ff == S_EXEC)
      else $error("commit went ahead over an untaken response");

   a_count_only_on_commit: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> $past(commit))
      else $error("count changed outside a commit");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == ST_FULL) |-> count_ff == CNT_W'(CAPACITY))
      else $error("full status with room in the list");
`endif

endmodule

### tb/sv/tb_bounded_array_list_engine_core.sv
// Self-checking bench for bounded_array_list_engine_core: a directed table, then weighted
// random list commands, checked against an in-bench list predictor.
// Depends on balist_pkg and the channel interfaces in balist_if.sv.
module tb_bounded_array_list_engine_core;
   import balist_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH  = CAPACITY_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   // Codes 10 to 15 carry no operation; the block must answer them as a no-op
   localparam logic [3:0] CMD_SPARE_LO = 4'd10;
   localparam logic [3:0] CMD_SPARE_HI = 4'd15;

   // How the random part leans: towards emptying, balanced, or towards filling
   typedef enum int {LEAN_SHRINK, LEAN_MIXED, LEAN_GROW} lean_type;

   typedef struct packed {
      logic [3:0]  code;
      logic [31:0] value;
      logic [7:0]  pos;
      logic [6:0]  pos2;
   } list_cmd_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] data;
      logic [7:0]  count;
      logic        is_empty;
   } list_reply_type;

   // One line of the directed table; the reply is typed in only where it is obvious
   typedef struct {
      list_cmd_type   cmd;
      bit             typed;
      list_reply_type reply;
   } bench_row_type;

   logic clock;
   logic reset;

   balist_req_if req_bus ();
   balist_rsp_if rsp_bus ();

   bounded_array_list_engine_core #(.CAPACITY(LIST_DEPTH)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // Predicted list contents and length
   logic [31:0] list_mem [LIST_DEPTH];
   int unsigned list_len;

   list_reply_type pending_replies [$];
   bench_row_type  bench_rows [$];

   int src_idle_pct  = 30;
   int sink_idle_pct = 64;
   int errors        = 0;
   int sent          = 0;
   int checked       = 0;
   int full_answers  = 0;
   int peak_len      = 0;
   int cycle_count   = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Work out the reply to one request and advance the predicted list
   function automatic list_reply_type apply_list_command(input list_cmd_type c);
      list_reply_type r;
      int unsigned i;
      int unsigned slot;
      logic [31:0] held;
      bit          has_room;
      bit          pos_ok;
      bit          pos2_ok;
      has_room = list_len < LIST_DEPTH;
      pos_ok   = c.pos < list_len;
      pos2_ok  = c.pos2 < list_len;
      r.status = ST_OK;
      r.data   = '0;
      case (c.code)
         CMD_CLEAR: list_len = 0;
         CMD_PREPEND, CMD_INSERT_AT, CMD_APPEND: begin
            // full takes priority over a bad insert position
            if (!has_room) begin
               r.status = ST_FULL;
            end else if (c.code == CMD_INSERT_AT && c.pos > list_len) begin
               r.status = ST_BADPOS;
            end else begin
               slot = (c.code == CMD_PREPEND) ? 0 : (c.code == CMD_APPEND) ? list_len : c.pos;
               for (i = list_len; i > slot; i--) list_mem[i] = list_mem[i-1];
               list_mem[slot] = c.value;
               list_len++;
            end
         end
         CMD_REMOVE_FIRST, CMD_REMOVE_AT: begin
            slot = (c.code == CMD_REMOVE_FIRST) ? 0 : c.pos;
            if (c.code == CMD_REMOVE_FIRST && list_len == 0) begin
               r.status = ST_EMPTY;
            end else if (c.code == CMD_REMOVE_AT && !pos_ok) begin
               r.status = ST_BADPOS;
            end else begin
               r.data = list_mem[slot];
               for (i = slot; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
               list_len--;
            end
         end
         CMD_READ_AT: begin
            if (!pos_ok) r.status = ST_BADPOS;
            else r.data = list_mem[c.pos];
         end
         CMD_REPLACE_AT: begin
            if (!pos_ok) begin
               r.status = ST_BADPOS;
            end else begin
               r.data = list_mem[c.pos];
               list_mem[c.pos] = c.value;
            end
         end
         CMD_SWAP: begin
            if (!pos_ok || !pos2_ok) begin
               r.status = ST_BADPOS;
            end else begin
               held = list_mem[c.pos];
               list_mem[c.pos] = list_mem[c.pos2];
               list_mem[c.pos2] = held;
            end
         end
         CMD_READ_HEAD: begin
            if (list_len == 0) r.status = ST_EMPTY;
            else r.data = list_mem[0];
         end
         default: ;
      endcase
      r.count    = 8'(list_len);
      r.is_empty = (list_len == 0);
      return r;
   endfunction

   // Add a line to the directed table; pass typed = 1 to give the reply by hand
   task automatic stim_row(input logic [3:0] code, input logic [31:0] value,
                           input logic [7:0] pos, input logic [6:0] pos2,
                           input bit typed = 1'b0, input status_type st = ST_OK,
                           input logic [31:0] data = '0, input int cnt = 0);
      bench_row_type row;
      row.cmd            = '{code: code, value: value, pos: pos, pos2: pos2};
      row.typed          = typed;
      row.reply.status   = st;
      row.reply.data     = data;
      row.reply.count    = 8'(cnt);
      row.reply.is_empty = (cnt == 0);
      bench_rows.push_back(row);
   endtask

   // Offer one request, with random idle cycles first; return at its accepting edge
   task automatic push_request(input list_cmd_type c, input bit typed,
                               input list_reply_type given);
      list_reply_type predicted;
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.cmd             <= c.code;
      req_bus.value           <= c.value;
      req_bus.position        <= c.pos;
      req_bus.second_position <= c.pos2;
      do @(posedge clock); while (!req_bus.ready);
      predicted = apply_list_command(c);
      if (predicted.status == ST_FULL) full_answers++;
      if (list_len > peak_len) peak_len = list_len;
      pending_replies.push_back(typed ? given : predicted);
      sent++;
   endtask

   // Hold the request side quiet until every outstanding response is back
   task automatic wait_for_replies();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
   endtask

   function automatic logic [3:0] draw_code(input lean_type lean);
      int roll;
      int grow_pct;
      int shrink_pct;
      roll       = $urandom_range(0, 99);
      grow_pct   = (lean == LEAN_GROW) ? 60 : (lean == LEAN_MIXED) ? 30 : 10;
      shrink_pct = (lean == LEAN_SHRINK) ? 50 : (lean == LEAN_MIXED) ? 25 : 10;
      // clear only when not filling, so the list still reaches full
      if (roll < 1) return (lean == LEAN_GROW) ? CMD_READ_HEAD : CMD_CLEAR;
      if (roll < 3) return 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      if (roll < 3 + grow_pct) begin
         case ($urandom_range(0, 2))
            0:       return CMD_PREPEND;
            1:       return CMD_INSERT_AT;
            default: return CMD_APPEND;
         endcase
      end
      if (roll < 3 + grow_pct + shrink_pct)
         return ($urandom_range(0, 1) != 0) ? CMD_REMOVE_AT : CMD_REMOVE_FIRST;
      case ($urandom_range(0, 3))
         0:       return CMD_READ_AT;
         1:       return CMD_REPLACE_AT;
         2:       return CMD_SWAP;
         default: return CMD_READ_HEAD;
      endcase
   endfunction

   // Mostly positions that hit the list, the rest anywhere in the field
   task automatic random_burst(input int n);
      list_cmd_type   c;
      list_reply_type none;
      lean_type       lean;
      int             k;
      none = '0;
      lean = LEAN_GROW;
      for (k = 0; k < n; k++) begin
         if (k % 150 == 149) lean = lean_type'($urandom_range(0, 2));
         c.code = draw_code(lean);
         case ($urandom_range(0, 7))
            0:       c.value = 32'h8000_0000;
            1:       c.value = 32'h7FFF_FFFF;
            2:       c.value = 32'hFFFF_FFFF;
            default: c.value = $urandom;
         endcase
         if ($urandom_range(0, 9) < 8) c.pos = 8'($urandom_range(0, list_len));
         else c.pos = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 9) < 8 && list_len > 0)
            c.pos2 = 7'($urandom_range(0, (list_len > 128) ? 127 : list_len - 1));
         else
            c.pos2 = 7'($urandom_range(0, 127));
         push_request(c, 1'b0, none);
      end
   endtask

   // Stimulus: reset, directed table, then three random phases with different idling
   initial begin
      int r;
      req_bus.valid           <= 1'b0;
      req_bus.cmd             <= CMD_CLEAR;
      req_bus.value           <= '0;
      req_bus.position        <= '0;
      req_bus.second_position <= '0;
      reset                   <= 1'b1;
      list_len = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty list: every access is refused, insert past the end too
      stim_row(CMD_READ_HEAD,    32'h0, 8'd0,   7'd0,   1, ST_EMPTY,  0, 0);
      stim_row(CMD_REMOVE_FIRST, 32'h0, 8'd0,   7'd0,   1, ST_EMPTY,  0, 0);
      stim_row(CMD_READ_AT,      32'h0, 8'd0,   7'd0,   1, ST_BADPOS, 0, 0);
      stim_row(CMD_REMOVE_AT,    32'h0, 8'd0,   7'd0,   1, ST_BADPOS, 0, 0);
      stim_row(CMD_REPLACE_AT,   32'h5, 8'd0,   7'd0,   1, ST_BADPOS, 0, 0);
      stim_row(CMD_SWAP,         32'h0, 8'd0,   7'd0,   1, ST_BADPOS, 0, 0);
      stim_row(CMD_INSERT_AT,    32'h9, 8'd1,   7'd0,   1, ST_BADPOS, 0, 0);
      // Build a short list from the value extremes; insert at the count appends
      stim_row(CMD_APPEND,    32'h7FFF_FFFF, 8'd0, 7'd0, 1, ST_OK, 0, 1);
      stim_row(CMD_PREPEND,   32'h8000_0000, 8'd0, 7'd0, 1, ST_OK, 0, 2);
      stim_row(CMD_INSERT_AT, 32'hFFFF_FFFF, 8'd2, 7'd0, 1, ST_OK, 0, 3);
      stim_row(CMD_INSERT_AT, 32'h1234_5678, 8'd1, 7'd0);
      stim_row(CMD_READ_AT,   32'h0,         8'd0, 7'd0);
      stim_row(CMD_SWAP,      32'h0,         8'd0, 7'd3);
      stim_row(CMD_SWAP,      32'h0,         8'd2, 7'd2);
      stim_row(CMD_REPLACE_AT, 32'h0,        8'd1, 7'd0);
      // Out-of-range indices, at the field extremes and just past the end
      stim_row(CMD_SWAP,    32'h0, 8'd0,   7'd127, 1, ST_BADPOS, 0, 4);
      stim_row(CMD_READ_AT, 32'h0, 8'd255, 7'd0,   1, ST_BADPOS, 0, 4);
      stim_row(CMD_READ_AT, 32'h0, 8'd4,   7'd0,   1, ST_BADPOS, 0, 4);
      stim_row(CMD_REMOVE_AT,    32'h0, 8'd3, 7'd0);
      stim_row(CMD_REMOVE_FIRST, 32'h0, 8'd0, 7'd0);
      stim_row(CMD_SPARE_HI, 32'hFFFF_FFFF, 8'd255, 7'd127, 1, ST_OK, 0, 2);
      stim_row(CMD_SPARE_LO, 32'h0,         8'd0,   7'd0);
      stim_row(CMD_READ_HEAD, 32'h0, 8'd0, 7'd0);
      stim_row(CMD_INSERT_AT, 32'h1, 8'd3, 7'd0, 1, ST_BADPOS, 0, 2);
      stim_row(CMD_CLEAR,     32'h0, 8'd0, 7'd0, 1, ST_OK,     0, 0);
      stim_row(CMD_READ_HEAD, 32'h0, 8'd0, 7'd0, 1, ST_EMPTY,  0, 0);
      // Fill to capacity, then push against the full list
      for (r = 0; r < LIST_DEPTH; r++) stim_row(CMD_APPEND, $urandom, 8'd0, 7'd0);
      stim_row(CMD_PREPEND,   32'h1, 8'd0,   7'd0,   1, ST_FULL,   0, LIST_DEPTH);
      stim_row(CMD_INSERT_AT, 32'h2, 8'd200, 7'd0,   1, ST_FULL,   0, LIST_DEPTH);
      stim_row(CMD_APPEND,    32'h3, 8'd0,   7'd0,   1, ST_FULL,   0, LIST_DEPTH);
      stim_row(CMD_READ_AT,   32'h0, 8'd128, 7'd0,   1, ST_BADPOS, 0, LIST_DEPTH);
      stim_row(CMD_SWAP,      32'h0, 8'd0,   7'd127);
      stim_row(CMD_REMOVE_AT, 32'h0, 8'd127, 7'd0);
      stim_row(CMD_INSERT_AT, 32'h8000_0000, 8'd127, 7'd0);
      stim_row(CMD_REMOVE_FIRST, 32'h0, 8'd0, 7'd0);

      foreach (bench_rows[i]) push_request(bench_rows[i].cmd, bench_rows[i].typed,
                                           bench_rows[i].reply);

      // Phase one: sender idles lightly, receiver heavily; drain once midway
      random_burst(165);
      wait_for_replies();
      random_burst(165);
      wait_for_replies();

      // Phase two: the other way round
      src_idle_pct  = 64;
      sink_idle_pct = 30;
      random_burst(330);
      wait_for_replies();

      // Phase three: full rate on both sides
      src_idle_pct  = 0;
      sink_idle_pct = 0;
      random_burst(328);

      wait_for_replies();
      repeat (8) @(posedge clock);

      $display("Sent %0d requests, checked %0d responses, %0d mismatches.",
               sent, checked, errors);
      $display("List full refusals: %0d; longest list held: %0d entries.",
               full_answers, peak_len);
      if (errors == 0) begin
         $display("bounded_array_list_engine_core: match");
      end else begin
         $display("bounded_array_list_engine_core: mismatch");
      end
      $finish;
   end

   // Receiver back-pressure: drop ready at random per the current phase
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
   end

   // Compare each accepted response with the oldest prediction, field by field
   always @(posedge clock) begin : check_replies
      list_reply_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: response with none outstanding: status %0d data %h count %0d",
                     $time, rsp_bus.status, rsp_bus.data, rsp_bus.count);
            errors++;
         end else begin
            want = pending_replies.pop_front();
            checked++;
            if (rsp_bus.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_bus.status);
               errors++;
            end
            if (rsp_bus.data !== want.data) begin
               $display("%0t: data expected %h actual %h", $time, want.data, rsp_bus.data);
               errors++;
            end
            if (rsp_bus.count !== want.count) begin
               $display("%0t: count expected %0d actual %0d", $time, want.count,
                        rsp_bus.count);
               errors++;
            end
            if (rsp_bus.is_empty !== want.is_empty) begin
               $display("%0t: is_empty expected %0d actual %0d", $time, want.is_empty,
                        rsp_bus.is_empty);
               errors++;
            end
         end
      end
   end

   // Watchdog: abandon the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d responses outstanding.",
                  cycle_count, pending_replies.size());
         $display("bounded_array_list_engine_core: mismatch");
         $finish;
      end
   end

endmodule
